FILE: design/cch_pkg.sv
// ----------------------------------------------------------------------------
// cch_pkg: shared types and constants for the compass heading block
// Word layouts, job codes, register indexes and the CORDIC angle table.
// ----------------------------------------------------------------------------
package cch_pkg;

  localparam int CORDIC_STEPS = 16;
  localparam int SAMPLE_BITS  = 16;

  localparam int SUM_W  = 24;
  localparam int DIV_W  = 44;
  localparam int QUO_W  = 18;
  localparam int CRD_W  = 28;
  localparam int ANG_W  = 34;
  localparam int STEP_W = 5;

  localparam logic signed [ANG_W-1:0] FULL_TURN = ANG_W'(64'sd360 <<< 22);
  localparam logic signed [ANG_W-1:0] HALF_TURN = ANG_W'(64'sd180 <<< 22);
  localparam logic [14:0] HEADING_UNITS = 15'd23040;

  // Input item kinds.
  localparam logic [1:0] KIND_HEAD  = 2'd0;
  localparam logic [1:0] KIND_CAL   = 2'd1;
  localparam logic [1:0] KIND_CLEAR = 2'd2;

  // Configuration register indexes.
  localparam logic [2:0] REG_HEAD_AVG = 3'd0;
  localparam logic [2:0] REG_CAL_AVG  = 3'd1;
  localparam logic [2:0] REG_MIN_X    = 3'd2;
  localparam logic [2:0] REG_MAX_X    = 3'd3;
  localparam logic [2:0] REG_MIN_Y    = 3'd4;
  localparam logic [2:0] REG_MAX_Y    = 3'd5;

  typedef struct packed {
    logic [1:0]         kind;
    logic signed [15:0] raw_x;
    logic signed [15:0] raw_y;
  } in_item_t;

  typedef struct packed {
    logic [14:0]        heading;
    logic               heading_valid;
    logic               range_error;
    logic signed [15:0] track_min_x;
    logic signed [15:0] track_max_x;
    logic signed [15:0] track_min_y;
    logic signed [15:0] track_max_y;
  } out_item_t;

  typedef enum logic [2:0] {
    OP_NOP, OP_CLEAR, OP_HEAD, OP_CAL, OP_RERR
  } op_t;

  // Job handed from the front end to the back end.
  typedef struct packed {
    op_t                      op;
    logic signed [SUM_W-1:0]  sum_x;
    logic signed [SUM_W-1:0]  sum_y;
    logic [7:0]               n;
  } job_t;

  typedef struct packed {
    logic [7:0]         head_avg;
    logic [7:0]         cal_avg;
    logic signed [15:0] min_x;
    logic signed [15:0] max_x;
    logic signed [15:0] min_y;
    logic signed [15:0] max_y;
  } cfg_t;

  typedef enum logic [2:0] {
    B_IDLE, B_SETUP, B_DIV, B_TRACK, B_CINIT, B_CORDIC, B_FINISH
  } back_state_t;

  // Arctangent of 2^-i in units of 2^-22 degree.
  function automatic logic [CRD_W-1:0] atan_val(input logic [STEP_W-1:0] i);
    logic [CRD_W-1:0] v;
    case (i)
      5'd0:  v = 28'd188743680;
      5'd1:  v = 28'd111421900;
      5'd2:  v = 28'd58872272;
      5'd3:  v = 28'd29884485;
      5'd4:  v = 28'd15000234;
      5'd5:  v = 28'd7507429;
      5'd6:  v = 28'd3754631;
      5'd7:  v = 28'd1877430;
      5'd8:  v = 28'd938729;
      5'd9:  v = 28'd469366;
      5'd10: v = 28'd234683;
      5'd11: v = 28'd117342;
      5'd12: v = 28'd58671;
      5'd13: v = 28'd29335;
      5'd14: v = 28'd14668;
      5'd15: v = 28'd7334;
      5'd16: v = 28'd3667;
      5'd17: v = 28'd1833;
      5'd18: v = 28'd917;
      5'd19: v = 28'd458;
      5'd20: v = 28'd229;
      5'd21: v = 28'd115;
      5'd22: v = 28'd57;
      5'd23: v = 28'd29;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

FILE: design/cch_front.sv
// ----------------------------------------------------------------------------
// cch_front: sample accumulation and job classification
// Sums raw samples into groups and emits one job per accepted word.
// ----------------------------------------------------------------------------
module cch_front import cch_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  cfg_t     cfg,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_item_t in_data,
  input  logic     q_full,
  output logic     push,
  output job_t     push_job
);

  logic signed [SUM_W-1:0] sum_x_r, sum_x_nxt, sum_y_r, sum_y_nxt;
  logic [7:0] count_r, count_nxt;
  logic       mode_r, mode_nxt;

  logic                    same;
  logic signed [SUM_W-1:0] new_x, new_y;
  logic [8:0]              new_cnt;
  logic [7:0]              n_eff;
  logic                    done;
  logic                    bad_range;

  assign in_ready = !q_full;
  assign push     = in_valid && in_ready;

  // Group arithmetic for the incoming word.
  always_comb begin
    same    = (mode_r == in_data.kind[0]);
    new_x   = (same ? sum_x_r : '0) + SUM_W'($signed(in_data.raw_x[SAMPLE_BITS-1:0]));
    new_y   = (same ? sum_y_r : '0) + SUM_W'($signed(in_data.raw_y[SAMPLE_BITS-1:0]));
    new_cnt = (same ? {1'b0, count_r} : 9'd0) + 9'd1;
    n_eff   = (in_data.kind == KIND_HEAD) ? cfg.head_avg : cfg.cal_avg;
    if (n_eff == 8'd0) begin
      n_eff = 8'd1;
    end
    done      = (new_cnt >= {1'b0, n_eff});
    bad_range = (cfg.max_x == cfg.min_x) || (cfg.max_y == cfg.min_y);
  end

  // Job word and next group state.
  always_comb begin
    sum_x_nxt = sum_x_r;
    sum_y_nxt = sum_y_r;
    count_nxt = count_r;
    mode_nxt  = mode_r;
    push_job.op    = OP_NOP;
    push_job.sum_x = new_x;
    push_job.sum_y = new_y;
    push_job.n     = n_eff;
    case (in_data.kind)
      KIND_CLEAR: begin
        push_job.op = OP_CLEAR;
        sum_x_nxt   = '0;
        sum_y_nxt   = '0;
        count_nxt   = '0;
      end
      KIND_HEAD, KIND_CAL: begin
        mode_nxt = in_data.kind[0];
        if (done) begin
          sum_x_nxt = '0;
          sum_y_nxt = '0;
          count_nxt = '0;
          if (in_data.kind == KIND_CAL) begin
            push_job.op = OP_CAL;
          end else begin
            push_job.op = bad_range ? OP_RERR : OP_HEAD;
          end
        end else begin
          sum_x_nxt = new_x;
          sum_y_nxt = new_y;
          count_nxt = new_cnt[7:0];
        end
      end
      default: push_job.op = OP_NOP;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_x_r <= '0;
      sum_y_r <= '0;
      count_r <= '0;
      mode_r  <= 1'b0;
    end else if (push) begin
      sum_x_r <= sum_x_nxt;
      sum_y_r <= sum_y_nxt;
      count_r <= count_nxt;
      mode_r  <= mode_nxt;
    end
  end

endmodule

FILE: design/cch_queue.sv
// ----------------------------------------------------------------------------
// cch_queue: two-entry job queue
// Decouples the front end from the back end.
// ----------------------------------------------------------------------------
module cch_queue import cch_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t push_job,
  output logic full,
  input  logic pop,
  output logic q_valid,
  output job_t q_job
);

  job_t       mem_r [2];
  logic       wr_r, rd_r;
  logic [1:0] cnt_r;

  assign full    = (cnt_r == 2'd2);
  assign q_valid = (cnt_r != 2'd0);
  assign q_job   = mem_r[rd_r];

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_r] <= push_job;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= 1'b0;
      rd_r  <= 1'b0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wr_r <= !wr_r;
      end
      if (pop) begin
        rd_r <= !rd_r;
      end
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end

endmodule

FILE: design/cch_back.sv
// ----------------------------------------------------------------------------
// cch_back: job execution unit
// Shared bit-serial divider, CORDIC vectoring unit, min/max tracking and
// the result register.
// ----------------------------------------------------------------------------
module cch_back import cch_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  cfg_t      cfg,
  input  logic      q_valid,
  input  job_t      q_job,
  output logic      pop,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  back_state_t state_r, state_nxt;

  job_t                    job_r;
  logic                    axis_r;
  logic [DIV_W-1:0]        d_r, v_r;
  logic                    neg_r, sat_r;
  logic [QUO_W-1:0]        q_r;
  logic [STEP_W-1:0]       cnt_r;
  logic signed [15:0]      res_x_r, res_y_r;
  logic signed [CRD_W-1:0] cx_r, cy_r;
  logic signed [ANG_W-1:0] cz_r;
  logic                    zero_r;
  logic signed [15:0]      tmin_x_r, tmax_x_r, tmin_y_r, tmax_y_r;
  logic                    out_valid_r;
  out_item_t               out_r;

  // Divider operand setup.
  logic signed [SUM_W-1:0] s_sel;
  logic signed [15:0]      lo, hi;
  logic signed [16:0]      lohi, hml;
  logic signed [25:0]      prod_a, den;
  logic signed [26:0]      num;
  logic [26:0]             un;
  logic [25:0]             ud;
  logic [SUM_W-1:0]        mag;
  logic [DIV_W-1:0]        d_set, v_set;
  logic                    neg_set;

  always_comb begin
    s_sel  = axis_r ? job_r.sum_y : job_r.sum_x;
    lo     = axis_r ? cfg.min_y : cfg.min_x;
    hi     = axis_r ? cfg.max_y : cfg.max_x;
    lohi   = 17'(lo) + 17'(hi);
    hml    = 17'(hi) - 17'(lo);
    prod_a = $signed({1'b0, job_r.n}) * lohi;
    den    = $signed({1'b0, job_r.n}) * hml;
    num    = (27'(s_sel) <<< 1) - 27'(prod_a);
    un     = num[26] ? 27'(-num) : 27'(num);
    ud     = den[25] ? 26'(-den) : 26'(den);
    mag    = s_sel[SUM_W-1] ? SUM_W'(-s_sel) : SUM_W'(s_sel);
    if (job_r.op == OP_HEAD) begin
      d_set   = (DIV_W'(un) << 16) + DIV_W'(ud);
      v_set   = DIV_W'(ud) << 1;
      neg_set = num[26] ^ den[25];
    end else begin
      d_set   = (DIV_W'(mag) << 1) + DIV_W'(job_r.n);
      v_set   = DIV_W'(job_r.n) << 1;
      neg_set = s_sel[SUM_W-1];
    end
  end

  // One restoring division step, then the signed 16-bit result.
  logic [DIV_W-1:0] shifted;
  logic             ge;
  logic [QUO_W-1:0] q_step;
  logic [15:0]      qs;
  logic signed [15:0] div_res;

  always_comb begin
    shifted = v_r << cnt_r;
    ge      = (d_r >= shifted);
    q_step  = q_r | (QUO_W'(ge) << cnt_r);
    if (sat_r || (q_step > QUO_W'(32768))) begin
      qs = 16'h8000;
    end else begin
      qs = q_step[15:0];
    end
    if (neg_r) begin
      div_res = $signed(16'(-qs));
    end else begin
      div_res = (qs == 16'h8000) ? 16'sh7fff : $signed(qs);
    end
  end

  // CORDIC rotation step. The angle table entries are positive, so they are
  // zero extended to the angle width.
  logic signed [CRD_W-1:0] dx, dy;
  logic signed [ANG_W-1:0] atan_s;
  logic signed [CRD_W-1:0] ix, iy;

  always_comb begin
    dx     = cy_r >>> cnt_r;
    dy     = cx_r >>> cnt_r;
    atan_s = $signed(ANG_W'(atan_val(cnt_r)));
    ix     = CRD_W'(res_x_r) <<< 8;
    iy     = CRD_W'(res_y_r) <<< 8;
  end

  // Final angle wrap and rounding to 1/64 degree.
  logic signed [ANG_W-1:0] ang;
  logic [ANG_W-1:0]        ang_rnd;
  logic [14:0]             hdg;

  always_comb begin
    ang = cz_r;
    if (ang < 0) begin
      ang = ang + FULL_TURN;
    end
    if (ang >= FULL_TURN) begin
      ang = ang - FULL_TURN;
    end
    ang_rnd = ($unsigned(ang) + ANG_W'(32768)) >> 16;
    hdg     = ang_rnd[14:0];
    if (hdg >= HEADING_UNITS) begin
      hdg = hdg - HEADING_UNITS;
    end
  end

  logic out_free;
  assign out_free = !out_valid_r || out_ready;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      B_IDLE: begin
        if (q_valid) begin
          unique case (q_job.op)
            OP_HEAD, OP_CAL: state_nxt = B_SETUP;
            OP_CLEAR:        state_nxt = B_TRACK;
            default:         state_nxt = B_FINISH;
          endcase
        end
      end
      B_SETUP: state_nxt = B_DIV;
      B_DIV: begin
        if (cnt_r == '0) begin
          if (!axis_r) begin
            state_nxt = B_SETUP;
          end else begin
            state_nxt = (job_r.op == OP_CAL) ? B_TRACK : B_CINIT;
          end
        end
      end
      B_TRACK:  state_nxt = B_FINISH;
      B_CINIT:  state_nxt = B_CORDIC;
      B_CORDIC: begin
        if (cnt_r == STEP_W'(CORDIC_STEPS - 1)) begin
          state_nxt = B_FINISH;
        end
      end
      B_FINISH: begin
        if (out_free) begin
          state_nxt = B_IDLE;
        end
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  // Outputs of the state machine.
  always_comb begin
    pop = (state_r == B_IDLE) && q_valid;
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    unique case (state_r)
      B_IDLE: begin
        job_r  <= q_job;
        axis_r <= 1'b0;
      end
      B_SETUP: begin
        d_r   <= d_set;
        v_r   <= v_set;
        neg_r <= neg_set;
        sat_r <= (d_set >= (v_set << QUO_W));
        q_r   <= '0;
        cnt_r <= STEP_W'(QUO_W - 1);
      end
      B_DIV: begin
        if (ge) begin
          d_r <= d_r - shifted;
        end
        q_r   <= q_step;
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == '0) begin
          axis_r <= 1'b1;
          if (!axis_r) begin
            res_x_r <= div_res;
          end else begin
            res_y_r <= div_res;
          end
        end
      end
      B_CINIT: begin
        zero_r <= (res_x_r == '0) && (res_y_r == '0);
        cnt_r  <= '0;
        if (ix < 0) begin
          cx_r <= -ix;
          cy_r <= -iy;
          cz_r <= HALF_TURN;
        end else begin
          cx_r <= ix;
          cy_r <= iy;
          cz_r <= '0;
        end
      end
      B_CORDIC: begin
        cnt_r <= cnt_r + 1'b1;
        if (cy_r < 0) begin
          cx_r <= cx_r - dx;
          cy_r <= cy_r + dy;
          cz_r <= cz_r - atan_s;
        end else begin
          cx_r <= cx_r + dx;
          cy_r <= cy_r - dy;
          cz_r <= cz_r + atan_s;
        end
      end
      default: ;
    endcase
  end

  // Tracked min/max values.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tmin_x_r <= 16'sh7fff;
      tmax_x_r <= 16'sh8000;
      tmin_y_r <= 16'sh7fff;
      tmax_y_r <= 16'sh8000;
    end else if (state_r == B_TRACK) begin
      if (job_r.op == OP_CLEAR) begin
        tmin_x_r <= 16'sh7fff;
        tmax_x_r <= 16'sh8000;
        tmin_y_r <= 16'sh7fff;
        tmax_y_r <= 16'sh8000;
      end else begin
        if (res_x_r < tmin_x_r) tmin_x_r <= res_x_r;
        if (res_x_r > tmax_x_r) tmax_x_r <= res_x_r;
        if (res_y_r < tmin_y_r) tmin_y_r <= res_y_r;
        if (res_y_r > tmax_y_r) tmax_y_r <= res_y_r;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if ((state_r == B_FINISH) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if ((state_r == B_FINISH) && out_free) begin
      out_r.heading_valid <= (job_r.op == OP_HEAD);
      out_r.heading       <= ((job_r.op == OP_HEAD) && !zero_r) ? hdg : '0;
      out_r.range_error   <= (job_r.op == OP_RERR);
      out_r.track_min_x   <= tmin_x_r;
      out_r.track_max_x   <= tmax_x_r;
      out_r.track_min_y   <= tmin_y_r;
      out_r.track_max_y   <= tmax_y_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

FILE: design/compass_calibrate_and_heading.sv
// A heading group takes two 18-step divisions plus 16 CORDIC steps in the back
// end. A word is taken whenever the two-entry job queue has room; the back end
// finishes one job at a time.
// Reset is synchronous, active low: register defaults, empty sums, empty tracking.
// ----------------------------------------------------------------------------
// compass_calibrate_and_heading: calibrated magnetometer compass
// Group averaging, min/max calibration tracking and CORDIC heading.
// ----------------------------------------------------------------------------
module compass_calibrate_and_heading import cch_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      cfg_we,
  input  logic [2:0] cfg_index,
  input  logic [15:0] cfg_wdata,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  cfg_t cfg_r;
  logic q_full, push, pop, q_valid;
  job_t push_job, q_job;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.head_avg <= 8'd1;
      cfg_r.cal_avg  <= 8'd1;
      cfg_r.min_x    <= -16'sd1024;
      cfg_r.max_x    <= 16'sd1024;
      cfg_r.min_y    <= -16'sd1024;
      cfg_r.max_y    <= 16'sd1024;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_HEAD_AVG: cfg_r.head_avg <= cfg_wdata[7:0];
        REG_CAL_AVG:  cfg_r.cal_avg  <= cfg_wdata[7:0];
        REG_MIN_X:    cfg_r.min_x    <= $signed(cfg_wdata);
        REG_MAX_X:    cfg_r.max_x    <= $signed(cfg_wdata);
        REG_MIN_Y:    cfg_r.min_y    <= $signed(cfg_wdata);
        REG_MAX_Y:    cfg_r.max_y    <= $signed(cfg_wdata);
        default: ;
      endcase
    end
  end

  cch_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_full   (q_full),
    .push     (push),
    .push_job (push_job)
  );

  cch_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .full     (q_full),
    .pop      (pop),
    .q_valid  (q_valid),
    .q_job    (q_job)
  );

  cch_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_valid   (q_valid),
    .q_job     (q_job),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

`ifndef ASSERT_OFF
  // A word never reports both a heading and a range error.
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_data.heading_valid && out_data.range_error))
    else $error("heading and range error both set");

  // Heading is zero whenever no heading was computed.
  a_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.heading_valid) |-> (out_data.heading == '0))
    else $error("heading nonzero without heading_valid");

  // Heading stays below a full turn.
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.heading < HEADING_UNITS))
    else $error("heading out of range");

  // The back end only takes a job that the queue holds.
  a_pop: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> q_valid)
    else $error("job taken from empty queue");
`endif

endmodule
